[design/ts_packet_field_parser_assert.svh]
// Assertion macros shared by the parser's checker.
`ifndef TS_PACKET_FIELD_PARSER_ASSERT_SVH
`define TS_PACKET_FIELD_PARSER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TSP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsp check failed");
// Next-cycle implication checked outside reset.
`define TSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsp check failed");
`endif

[design/tspfp_pkg.sv]
// Package with kinds, parse phases and field widths of the transport packet parser.
package tspfp_pkg;
    localparam int PacketBytesDefault = 188;
    localparam int KindW = 4;
    localparam int ValueW = 42;
    localparam int PhaseW = 5;

    localparam logic [KindW-1:0] K_HDR = 4'd0;
    localparam logic [KindW-1:0] K_AF = 4'd1;
    localparam logic [KindW-1:0] K_PCR = 4'd2;
    localparam logic [KindW-1:0] K_OPCR = 4'd3;
    localparam logic [KindW-1:0] K_SPLICE = 4'd4;
    localparam logic [KindW-1:0] K_PRIV_LEN = 4'd5;
    localparam logic [KindW-1:0] K_PRIV = 4'd6;
    localparam logic [KindW-1:0] K_EXT = 4'd7;
    localparam logic [KindW-1:0] K_LTW = 4'd8;
    localparam logic [KindW-1:0] K_RATE = 4'd9;
    localparam logic [KindW-1:0] K_SEAMLESS = 4'd10;
    localparam logic [KindW-1:0] K_PAYLOAD = 4'd11;
    localparam logic [KindW-1:0] K_END = 4'd12;
    localparam logic [KindW-1:0] K_SYNC_ERR = 4'd13;
    localparam logic [KindW-1:0] K_TEI_ERR = 4'd14;

    localparam logic [PhaseW-1:0] PH_IDLE = 5'd0;
    localparam logic [PhaseW-1:0] PH_HDR = 5'd1;
    localparam logic [PhaseW-1:0] PH_AF_LEN = 5'd2;
    localparam logic [PhaseW-1:0] PH_AF_FLAGS = 5'd3;
    localparam logic [PhaseW-1:0] PH_PCR = 5'd4;
    localparam logic [PhaseW-1:0] PH_OPCR = 5'd5;
    localparam logic [PhaseW-1:0] PH_SPLICE = 5'd6;
    localparam logic [PhaseW-1:0] PH_PRIV_LEN = 5'd7;
    localparam logic [PhaseW-1:0] PH_PRIV = 5'd8;
    localparam logic [PhaseW-1:0] PH_EXT_LEN = 5'd9;
    localparam logic [PhaseW-1:0] PH_EXT_FLAGS = 5'd10;
    localparam logic [PhaseW-1:0] PH_LTW = 5'd11;
    localparam logic [PhaseW-1:0] PH_RATE = 5'd12;
    localparam logic [PhaseW-1:0] PH_SEAMLESS = 5'd13;
    localparam logic [PhaseW-1:0] PH_EXT_RES = 5'd14;
    localparam logic [PhaseW-1:0] PH_STUFF = 5'd15;
    localparam logic [PhaseW-1:0] PH_PAYLOAD = 5'd16;
    localparam logic [PhaseW-1:0] PH_SKIP = 5'd17;
    localparam logic [PhaseW-1:0] PH_DROP = 5'd18;

    localparam logic [7:0] SyncByte = 8'h47;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ValueW-1:0] value;
        logic last;
    } result_t;

    typedef struct packed {
        logic [7:0] pos;
        logic [PhaseW-1:0] phase;
        logic [1:0] afc;
        logic [7:0] af_left;
        logic [4:0] af_flags;
        logic [2:0] ext_flags;
        logic [7:0] ext_left;
        logic [7:0] priv_left;
        logic [47:0] shift;
        logic [2:0] seen;
        logic dropped;
    } parse_state_t;
endpackage

[design/tspfp_step.sv]
// Next-state and result logic for one packet byte.
module tspfp_step #(
    parameter int PACKET_BYTES = tspfp_pkg::PacketBytesDefault
) (
    input  tspfp_pkg::parse_state_t cur,
    input  logic [7:0]              data_byte,
    input  logic                    first_of_packet,
    output tspfp_pkg::parse_state_t nxt,
    output logic                    res_valid,
    output tspfp_pkg::result_t      res
);
    localparam logic [7:0] AfMax = 8'(PACKET_BYTES - 5);
    localparam logic [7:0] LastPos = 8'(PACKET_BYTES - 1);

    tspfp_pkg::parse_state_t s;
    logic done;
    logic run;
    logic [2:0] need;
    logic [47:0] sh;

    // Choose the next pending adaptation section.
    function automatic tspfp_pkg::parse_state_t af_next(input tspfp_pkg::parse_state_t st);
        tspfp_pkg::parse_state_t r;
        r = st;
        r.shift = '0;
        r.seen = '0;
        priority if (st.af_flags[4]) begin
            r.af_flags[4] = 1'b0; r.phase = tspfp_pkg::PH_PCR;
        end else if (st.af_flags[3]) begin
            r.af_flags[3] = 1'b0; r.phase = tspfp_pkg::PH_OPCR;
        end else if (st.af_flags[2]) begin
            r.af_flags[2] = 1'b0; r.phase = tspfp_pkg::PH_SPLICE;
        end else if (st.af_flags[1]) begin
            r.af_flags[1] = 1'b0; r.phase = tspfp_pkg::PH_PRIV_LEN;
        end else if (st.af_flags[0]) begin
            r.af_flags[0] = 1'b0; r.phase = tspfp_pkg::PH_EXT_LEN;
        end else begin
            r.phase = tspfp_pkg::PH_STUFF; r.shift = st.shift; r.seen = st.seen;
        end
        return r;
    endfunction

    function automatic tspfp_pkg::parse_state_t ext_next(input tspfp_pkg::parse_state_t st);
        tspfp_pkg::parse_state_t r;
        r = st;
        priority if (st.ext_left == 8'd0) begin
            r = af_next(st);
        end else if (st.ext_flags[2]) begin
            r.ext_flags[2] = 1'b0; r.phase = tspfp_pkg::PH_LTW; r.shift = '0; r.seen = '0;
        end else if (st.ext_flags[1]) begin
            r.ext_flags[1] = 1'b0; r.phase = tspfp_pkg::PH_RATE; r.shift = '0; r.seen = '0;
        end else if (st.ext_flags[0]) begin
            r.ext_flags[0] = 1'b0; r.phase = tspfp_pkg::PH_SEAMLESS; r.shift = '0; r.seen = '0;
        end else begin
            r.phase = tspfp_pkg::PH_EXT_RES;
        end
        return r;
    endfunction

    always_comb begin
        s = cur;
        done = 1'b0;
        need = 3'd5;
        sh = {cur.shift[39:0], data_byte};
        res_valid = 1'b0;
        res.kind = tspfp_pkg::K_END;
        res.value = '0;
        res.last = 1'b0;
        run = first_of_packet || (cur.phase != tspfp_pkg::PH_IDLE);
        if (first_of_packet) begin
            s = '0;
            s.phase = tspfp_pkg::PH_HDR;
            sh = {40'd0, data_byte};
        end
        unique case (s.phase)
            tspfp_pkg::PH_IDLE, tspfp_pkg::PH_SKIP, tspfp_pkg::PH_DROP: begin
            end
            tspfp_pkg::PH_HDR: begin
                if (s.pos == 8'd0) begin
                    if (data_byte != tspfp_pkg::SyncByte) begin
                        s.dropped = 1'b1; s.phase = tspfp_pkg::PH_DROP;
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_SYNC_ERR;
                        res.value = 42'(data_byte);
                    end
                end else if (s.pos == 8'd1 && data_byte[7]) begin
                    s.dropped = 1'b1; s.phase = tspfp_pkg::PH_DROP;
                    res_valid = 1'b1; res.kind = tspfp_pkg::K_TEI_ERR;
                    res.value = 42'(data_byte);
                end else begin
                    s.shift = {24'd0, sh[23:0]};
                    if (s.pos >= 8'd3) begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_HDR;
                        res.value = 42'(sh[23:0]);
                        s.afc = data_byte[5:4];
                        if (data_byte[5]) s.phase = tspfp_pkg::PH_AF_LEN;
                        else s.phase = data_byte[4] ? tspfp_pkg::PH_PAYLOAD
                                                    : tspfp_pkg::PH_SKIP;
                    end
                end
            end
            tspfp_pkg::PH_AF_LEN: begin
                s.af_left = (data_byte < AfMax) ? data_byte : AfMax;
                if (data_byte == 8'd0) begin
                    res_valid = 1'b1; res.kind = tspfp_pkg::K_AF; res.value = '0;
                    s.phase = s.afc[0] ? tspfp_pkg::PH_PAYLOAD : tspfp_pkg::PH_SKIP;
                end else begin
                    s.shift = {40'd0, data_byte}; s.phase = tspfp_pkg::PH_AF_FLAGS;
                end
            end
            tspfp_pkg::PH_PAYLOAD: begin
                res_valid = 1'b1; res.kind = tspfp_pkg::K_PAYLOAD;
                res.value = 42'(data_byte);
            end
            default: begin
                // Adaptation field body.
                unique case (s.phase)
                    tspfp_pkg::PH_AF_FLAGS: begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_AF;
                        res.value = 42'({s.shift[7:0], data_byte});
                        s.af_flags = data_byte[4:0]; done = 1'b1;
                    end
                    tspfp_pkg::PH_PCR, tspfp_pkg::PH_OPCR: begin
                        s.shift = sh; s.seen = s.seen + 3'd1;
                        if (s.seen >= 3'd6) begin
                            res_valid = 1'b1;
                            res.kind = (s.phase == tspfp_pkg::PH_PCR) ? tspfp_pkg::K_PCR
                                                                     : tspfp_pkg::K_OPCR;
                            res.value = {sh[47:15], sh[8:0]};
                            done = 1'b1;
                        end
                    end
                    tspfp_pkg::PH_SPLICE: begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_SPLICE;
                        res.value = 42'(data_byte); done = 1'b1;
                    end
                    tspfp_pkg::PH_PRIV_LEN: begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_PRIV_LEN;
                        res.value = 42'(data_byte); s.priv_left = data_byte;
                        if (data_byte == 8'd0) done = 1'b1;
                        else s.phase = tspfp_pkg::PH_PRIV;
                    end
                    tspfp_pkg::PH_PRIV: begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_PRIV;
                        res.value = 42'(data_byte);
                        if (s.priv_left != 8'd0) s.priv_left = s.priv_left - 8'd1;
                        done = (s.priv_left == 8'd0);
                    end
                    tspfp_pkg::PH_EXT_LEN: begin
                        if (data_byte == 8'd0) begin
                            res_valid = 1'b1; res.kind = tspfp_pkg::K_EXT;
                            res.value = '0; done = 1'b1;
                        end else begin
                            s.ext_left = data_byte; s.shift = {40'd0, data_byte};
                            s.phase = tspfp_pkg::PH_EXT_FLAGS;
                        end
                    end
                    tspfp_pkg::PH_EXT_FLAGS: begin
                        res_valid = 1'b1; res.kind = tspfp_pkg::K_EXT;
                        res.value = 42'({s.shift[7:0], data_byte});
                        s.ext_flags = data_byte[7:5];
                        if (s.ext_left != 8'd0) s.ext_left = s.ext_left - 8'd1;
                        s = ext_next(s);
                    end
                    tspfp_pkg::PH_LTW, tspfp_pkg::PH_RATE, tspfp_pkg::PH_SEAMLESS: begin
                        need = (s.phase == tspfp_pkg::PH_LTW) ? 3'd2 :
                               (s.phase == tspfp_pkg::PH_RATE) ? 3'd3 : 3'd5;
                        s.shift = sh; s.seen = s.seen + 3'd1;
                        if (s.ext_left != 8'd0) s.ext_left = s.ext_left - 8'd1;
                        if (s.seen >= need) begin
                            res_valid = 1'b1;
                            unique case (s.phase)
                                tspfp_pkg::PH_LTW: begin
                                    res.kind = tspfp_pkg::K_LTW;
                                    res.value = 42'(sh[15:0]);
                                end
                                tspfp_pkg::PH_RATE: begin
                                    res.kind = tspfp_pkg::K_RATE;
                                    res.value = 42'(sh[21:0]);
                                end
                                default: begin
                                    res.kind = tspfp_pkg::K_SEAMLESS;
                                    res.value = {5'd0, sh[39:36], sh[35:33], sh[31:17],
                                                 sh[15:1]};
                                end
                            endcase
                            s = ext_next(s);
                        end else if (s.ext_left == 8'd0) begin
                            done = 1'b1;
                        end
                    end
                    tspfp_pkg::PH_EXT_RES: begin
                        if (s.ext_left != 8'd0) s.ext_left = s.ext_left - 8'd1;
                        if (s.ext_left == 8'd0) done = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (s.af_left != 8'd0) s.af_left = s.af_left - 8'd1;
                if (s.af_left == 8'd0)
                    s.phase = s.afc[0] ? tspfp_pkg::PH_PAYLOAD : tspfp_pkg::PH_SKIP;
                else if (done) s = af_next(s);
            end
        endcase
        if (s.pos >= LastPos) begin
            s.phase = tspfp_pkg::PH_IDLE;
            s.pos = '0;
            if (!res_valid && !s.dropped) begin
                res_valid = 1'b1; res.kind = tspfp_pkg::K_END; res.value = '0;
            end
            res.last = res_valid;
        end else begin
            s.pos = s.pos + 8'd1;
        end
        if (!run) begin
            s = cur;
            res_valid = 1'b0;
        end
        nxt = s;
    end
endmodule

[design/ts_packet_field_parser.sv]
// Latency: a byte's result appears on the master side the cycle after the byte is accepted.
// Throughput: one byte per cycle; s_tready drops only while the result register is
// full and stalled, a single register stage between the two sides.
// Reset: aresetn (synchronous, active low) returns the parser to waiting for a packet
// start and empties the result register.
module ts_packet_field_parser #(
    parameter int PACKET_BYTES = tspfp_pkg::PacketBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // first_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [41:0] field_value, zero fill above
    output logic [3:0]  m_tuser,   // [3:0] item_kind
    output logic        m_tlast    // last_of_packet
);
    tspfp_pkg::parse_state_t state_reg, state_next;
    tspfp_pkg::result_t res_reg, res_c;
    logic valid_reg, res_valid_c, take;

    tspfp_step #(.PACKET_BYTES(PACKET_BYTES)) u_step (
        .cur(state_reg), .data_byte(s_tdata), .first_of_packet(s_tuser),
        .nxt(state_next), .res_valid(res_valid_c), .res(res_c)
    );

    assign s_tready = !valid_reg || m_tready;
    assign take = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (take) state_reg <= state_next;
            if (take) valid_reg <= res_valid_c;
            else if (m_tready) valid_reg <= 1'b0;
        end
        if (take) res_reg <= res_c;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {6'd0, res_reg.value};
    assign m_tuser = res_reg.kind;
    assign m_tlast = res_reg.last;
endmodule

[design/tspfp_checker.sv]
// Port-level checker for the transport packet parser, bound to the top level.
`include "ts_packet_field_parser_assert.svh"
module tspfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    `TSP_ASSERT_IMPL(a_kind_range, aclk, aresetn, m_tvalid, m_tuser != 4'd15)
    `TSP_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[47:42] == 6'd0)
    `TSP_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
    `TSP_ASSERT_IMPL(a_end_last, aclk, aresetn, m_tvalid && m_tuser == tspfp_pkg::K_END, m_tlast)
    `TSP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind ts_packet_field_parser tspfp_checker u_checker (.*);

[tb/ts_packet_field_parser_tb.sv]
// Testbench for the transport packet field parser: directed table and random packets.
`timescale 1ns / 100ps

module ts_packet_field_parser_tb;
    localparam int PKT = tspfp_pkg::PacketBytesDefault;
    localparam int ITEMS = 1100;

    typedef struct {
        logic [7:0]                   data;
        logic                         first;
        logic                         has_exp;
        logic [tspfp_pkg::KindW-1:0]  kind;
        logic [tspfp_pkg::ValueW-1:0] value;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    ts_packet_field_parser DUT (.*);

    always #4 aclk = ~aclk;

    // Predictor state.
    logic [7:0]                   pos_q;
    logic [tspfp_pkg::PhaseW-1:0] phase_q;
    logic [1:0]                   afc_q;
    logic [7:0]                   af_left_q;
    logic [4:0]                   af_flags_q;
    logic [2:0]                   ext_flags_q;
    logic [7:0]                   ext_left_q;
    logic [7:0]                   priv_left_q;
    logic [47:0]                  shift_q;
    logic [2:0]                   seen_q;
    logic                         dropped_q;

    tspfp_pkg::result_t expected_results[$];
    int      errors = 0;
    int      rx_idle = 0;
    bit      quiet_tail = 0;
    bit      hold_off = 0;

    function automatic void parser_clear();
        pos_q = 0; phase_q = tspfp_pkg::PH_IDLE; afc_q = 0; af_left_q = 0; af_flags_q = 0;
        ext_flags_q = 0; ext_left_q = 0; priv_left_q = 0; shift_q = 0; seen_q = 0;
        dropped_q = 0;
    endfunction

    function automatic void start_field(logic [tspfp_pkg::PhaseW-1:0] ph);
        phase_q = ph; shift_q = 0; seen_q = 0;
    endfunction

    function automatic void after_adaptation();
        phase_q = afc_q[0] ? tspfp_pkg::PH_PAYLOAD : tspfp_pkg::PH_SKIP;
    endfunction

    function automatic void next_af_section();
        if (af_flags_q[4]) begin
            af_flags_q[4] = 0; start_field(tspfp_pkg::PH_PCR);
        end else if (af_flags_q[3]) begin
            af_flags_q[3] = 0; start_field(tspfp_pkg::PH_OPCR);
        end else if (af_flags_q[2]) begin
            af_flags_q[2] = 0; start_field(tspfp_pkg::PH_SPLICE);
        end else if (af_flags_q[1]) begin
            af_flags_q[1] = 0; start_field(tspfp_pkg::PH_PRIV_LEN);
        end else if (af_flags_q[0]) begin
            af_flags_q[0] = 0; start_field(tspfp_pkg::PH_EXT_LEN);
        end else begin
            phase_q = tspfp_pkg::PH_STUFF;
        end
    endfunction

    function automatic void next_ext_section();
        if (ext_left_q == 0) begin
            next_af_section();
        end else if (ext_flags_q[2]) begin
            ext_flags_q[2] = 0; start_field(tspfp_pkg::PH_LTW);
        end else if (ext_flags_q[1]) begin
            ext_flags_q[1] = 0; start_field(tspfp_pkg::PH_RATE);
        end else if (ext_flags_q[0]) begin
            ext_flags_q[0] = 0; start_field(tspfp_pkg::PH_SEAMLESS);
        end else begin
            phase_q = tspfp_pkg::PH_EXT_RES;
        end
    endfunction

    // Adaptation-field byte; returns 1 and fills kind/value when a field completes.
    function automatic bit adaptation_byte(logic [7:0] b,
                                           output logic [tspfp_pkg::KindW-1:0] k,
                                           output logic [tspfp_pkg::ValueW-1:0] v);
        bit got;
        bit done;
        int need;
        got = 0; done = 0; k = '0; v = '0;
        case (phase_q)
            tspfp_pkg::PH_AF_FLAGS: begin
                got = 1; k = tspfp_pkg::K_AF; v = 42'({shift_q[7:0], b});
                af_flags_q = b[4:0]; done = 1;
            end
            tspfp_pkg::PH_PCR, tspfp_pkg::PH_OPCR: begin
                shift_q = {shift_q[39:0], b}; seen_q++;
                if (seen_q >= 6) begin
                    got = 1;
                    k = (phase_q == tspfp_pkg::PH_PCR) ? tspfp_pkg::K_PCR : tspfp_pkg::K_OPCR;
                    v = {shift_q[47:15], shift_q[8:0]}; done = 1;
                end
            end
            tspfp_pkg::PH_SPLICE: begin
                got = 1; k = tspfp_pkg::K_SPLICE; v = 42'(b); done = 1;
            end
            tspfp_pkg::PH_PRIV_LEN: begin
                got = 1; k = tspfp_pkg::K_PRIV_LEN; v = 42'(b); priv_left_q = b;
                if (b == 0) done = 1; else phase_q = tspfp_pkg::PH_PRIV;
            end
            tspfp_pkg::PH_PRIV: begin
                got = 1; k = tspfp_pkg::K_PRIV; v = 42'(b);
                if (priv_left_q > 0) priv_left_q--;
                done = (priv_left_q == 0);
            end
            tspfp_pkg::PH_EXT_LEN: begin
                if (b == 0) begin
                    got = 1; k = tspfp_pkg::K_EXT; v = 0; done = 1;
                end else begin
                    ext_left_q = b; shift_q = 48'(b); phase_q = tspfp_pkg::PH_EXT_FLAGS;
                end
            end
            tspfp_pkg::PH_EXT_FLAGS: begin
                got = 1; k = tspfp_pkg::K_EXT; v = 42'({shift_q[7:0], b});
                ext_flags_q = b[7:5];
                if (ext_left_q > 0) ext_left_q--;
                next_ext_section();
            end
            tspfp_pkg::PH_LTW, tspfp_pkg::PH_RATE, tspfp_pkg::PH_SEAMLESS: begin
                need = (phase_q == tspfp_pkg::PH_LTW) ? 2 :
                       (phase_q == tspfp_pkg::PH_RATE) ? 3 : 5;
                shift_q = {shift_q[39:0], b}; seen_q++;
                if (ext_left_q > 0) ext_left_q--;
                if (seen_q >= need) begin
                    got = 1;
                    if (phase_q == tspfp_pkg::PH_LTW) begin
                        k = tspfp_pkg::K_LTW; v = 42'(shift_q[15:0]);
                    end else if (phase_q == tspfp_pkg::PH_RATE) begin
                        k = tspfp_pkg::K_RATE; v = 42'(shift_q[21:0]);
                    end else begin
                        k = tspfp_pkg::K_SEAMLESS;
                        v = 42'({shift_q[39:36], shift_q[35:33], shift_q[31:17],
                                 shift_q[15:1]});
                    end
                    next_ext_section();
                end else if (ext_left_q == 0) begin
                    done = 1;
                end
            end
            tspfp_pkg::PH_EXT_RES: begin
                if (ext_left_q > 0) ext_left_q--;
                if (ext_left_q == 0) done = 1;
            end
            default: ;
        endcase
        if (af_left_q > 0) af_left_q--;
        if (af_left_q == 0) after_adaptation();
        else if (done) next_af_section();
        return got;
    endfunction

    // Advances the predictor by one accepted byte and queues any result.
    function automatic void predict_byte(logic [7:0] b, logic first);
        tspfp_pkg::result_t r;
        bit got;
        logic [7:0] p;
        got = 0; r = '0;
        if (first) begin
            parser_clear(); phase_q = tspfp_pkg::PH_HDR;
        end else if (phase_q == tspfp_pkg::PH_IDLE) begin
            return;
        end
        p = pos_q;
        case (phase_q)
            tspfp_pkg::PH_HDR: begin
                if (p == 0) begin
                    if (b != tspfp_pkg::SyncByte) begin
                        dropped_q = 1; phase_q = tspfp_pkg::PH_DROP;
                        got = 1; r.kind = tspfp_pkg::K_SYNC_ERR; r.value = 42'(b);
                    end
                end else if (p == 1 && b[7]) begin
                    dropped_q = 1; phase_q = tspfp_pkg::PH_DROP;
                    got = 1; r.kind = tspfp_pkg::K_TEI_ERR; r.value = 42'(b);
                end else begin
                    shift_q = {24'd0, shift_q[15:0], b};
                    if (p >= 3) begin
                        got = 1; r.kind = tspfp_pkg::K_HDR; r.value = 42'(shift_q[23:0]);
                        afc_q = b[5:4];
                        if (afc_q[1]) phase_q = tspfp_pkg::PH_AF_LEN;
                        else after_adaptation();
                    end
                end
            end
            tspfp_pkg::PH_AF_LEN: begin
                af_left_q = (b < PKT - 5) ? b : 8'(PKT - 5);
                if (af_left_q == 0) begin
                    got = 1; r.kind = tspfp_pkg::K_AF; r.value = 42'({b, 8'h00});
                    after_adaptation();
                end else begin
                    shift_q = 48'(b); phase_q = tspfp_pkg::PH_AF_FLAGS;
                end
            end
            tspfp_pkg::PH_PAYLOAD: begin
                got = 1; r.kind = tspfp_pkg::K_PAYLOAD; r.value = 42'(b);
            end
            tspfp_pkg::PH_SKIP, tspfp_pkg::PH_DROP: ;
            default: got = adaptation_byte(b, r.kind, r.value);
        endcase
        if (int'(p) + 1 >= PKT) begin
            phase_q = tspfp_pkg::PH_IDLE; pos_q = 0;
            if (!got && !dropped_q) begin
                got = 1; r.kind = tspfp_pkg::K_END; r.value = 0;
            end
            r.last = 1;
        end else begin
            pos_q = p + 8'd1;
        end
        if (got) expected_results.push_back(r);
    endfunction

    // Sends one request, with a random gap before it while idling is allowed.
    task automatic send_byte(logic [7:0] b, logic first);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, first);
    endtask

    // Well-formed packet with a random adaptation field; sometimes broken or cut short.
    task automatic send_random_packet(inout int items);
        logic [7:0] pkt[PKT];
        int n, afl, cut, mode, extra;
        logic [7:0] fl, el;
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        mode = $urandom_range(0, 19);
        pkt[0] = (mode == 0) ? 8'($urandom) : tspfp_pkg::SyncByte;
        pkt[1][7] = (mode == 1);
        pkt[3][5:4] = (mode < 4) ? 2'($urandom) : 2'b11;
        afl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 60);
        pkt[4] = 8'(afl);
        fl = 8'($urandom); pkt[5] = fl;
        n = 6;
        if (fl[4]) n += 6;
        if (fl[3]) n += 6;
        if (fl[2]) n += 1;
        if (fl[1]) begin
            pkt[n] = 8'($urandom_range(0, 6)); n += 1 + int'(pkt[n]);
        end
        if (fl[0] && n < PKT - 2) begin
            el = 8'($urandom_range(0, 14)); pkt[n] = el;
        end
        cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, PKT - 1) : PKT;
        for (int i = 0; i < cut; i++) send_byte(pkt[i], i == 0);
        items += cut;
        if ($urandom_range(0, 9) == 0) begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++) send_byte(8'($urandom), 1'b0);
            items += extra;
        end
    endtask

    // Result side: random stall bursts, one long hold-off, and the field checks.
    always @(posedge aclk) begin
        tspfp_pkg::result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind=%0d value=%0h", m_tuser, m_tdata);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("item_kind: expected %0d, got %0d", e.kind, m_tuser); errors++;
                    end
                    if (m_tdata !== {6'd0, e.value}) begin
                        $error("field_value: expected %0h, got %0h", e.value, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_of_packet: expected %0b, got %0b", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (quiet_tail) begin
                m_tready <= 1'b1;
            end else if (rx_idle > 0) begin
                rx_idle--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                rx_idle = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off early in the random part, while requests keep coming.
    initial begin
        @(posedge aclk);
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_off = 1;
        repeat (200) @(posedge aclk);
        hold_off = 0;
    end

    stim_row_t directed[$];

    task automatic add_row(logic [7:0] d, logic f, logic h = 0,
                           logic [tspfp_pkg::KindW-1:0] k = '0,
                           logic [tspfp_pkg::ValueW-1:0] v = '0);
        stim_row_t r;
        r.data = d; r.first = f; r.has_exp = h; r.kind = k; r.value = v;
        directed.push_back(r);
    endtask

    initial begin
        int items;
        parser_clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Byte outside a packet, bad sync, TEI set, header with maximal fields,
        // adaptation length zero, restart inside a packet.
        add_row(8'hFF, 0);
        add_row(8'h00, 1, 1, tspfp_pkg::K_SYNC_ERR, 42'h00);
        add_row(8'h47, 1);
        add_row(8'hFF, 0, 1, tspfp_pkg::K_TEI_ERR, 42'hFF);
        add_row(8'h47, 1);
        add_row(8'h7F, 0);
        add_row(8'hFF, 0);
        add_row(8'hFF, 0, 1, tspfp_pkg::K_HDR, 42'h7FFFFF);
        add_row(8'h00, 0, 1, tspfp_pkg::K_AF, 42'h0);
        add_row(8'hAB, 0, 1, tspfp_pkg::K_PAYLOAD, 42'hAB);
        add_row(8'h47, 1);
        add_row(8'h00, 0);
        add_row(8'h00, 0);
        add_row(8'h30, 0, 1, tspfp_pkg::K_HDR, 42'h000030);
        add_row(8'hFF, 0);
        add_row(8'h1F, 0, 1, tspfp_pkg::K_AF, 42'hFF1F);
        for (int i = 0; i < 6; i++) add_row(8'hFF, 0);
        foreach (directed[i]) begin
            send_byte(directed[i].data, directed[i].first);
            if (directed[i].has_exp && (expected_results.size() == 0 ||
                expected_results[$].kind !== directed[i].kind ||
                expected_results[$].value !== directed[i].value)) begin
                $error("directed row %0d: table disagrees with predictor", i);
                errors++;
            end
        end
        // Random packets with PCR, OPCR, splice, private data and extension fields.
        items = directed.size();
        while (items < ITEMS) begin
            if (items > ITEMS - 3 * PKT) quiet_tail = 1;
            send_random_packet(items);
        end
        s_tvalid <= 1'b0;
        quiet_tail = 1;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
